### rtl/qau_pkg.sv
// Package for the quaternion arithmetic unit: widths, command codes, result struct.
// No dependencies.
`default_nettype none
package qau_pkg;
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CMDW = 3;
    localparam int TOLW = 17;
    localparam int SW = 65;   // sum of squares width

    typedef enum logic [CMDW-1:0] {
        CMD_MULT = 3'd0,
        CMD_SCALE = 3'd1,
        CMD_CONJ = 3'd2,
        CMD_INV = 3'd3,
        CMD_NORM = 3'd4,
        CMD_DIFF = 3'd5,
        CMD_UNIT = 3'd6,
        CMD_SPARE = 3'd7
    } cmd_t;

    typedef logic signed [DW-1:0] comp_t;

    typedef struct packed {
        comp_t r0;
        comp_t r1;
        comp_t r2;
        comp_t r3;
        logic unit_flag;
        logic zero_flag;
        logic sat_flag;
    } res_t;

    // Clamp a wide signed value to DW bits; returns {sat, value}.
    function automatic logic [DW:0] sat_clamp(input logic signed [80:0] v);
        logic signed [80:0] mx;
        logic signed [80:0] mn;
        mx = 81'sd2147483647;
        mn = -81'sd2147483648;
        if (v > mx) begin
            sat_clamp = {1'b1, mx[DW-1:0]};
        end else if (v < mn) begin
            sat_clamp = {1'b1, mn[DW-1:0]};
        end else begin
            sat_clamp = {1'b0, v[DW-1:0]};
        end
    endfunction
endpackage
`default_nettype wire

### rtl/quaternion_arith_unit_top.sv
// Top level of the quaternion arithmetic unit: stream ports, pipeline, output skid.
// Depends on qau_pkg and qau_div_stage.
//
//  channel | direction | payload
//  s_axis  | in        | tdata: cmd, a_real..a_k, b_real..b_k, scale_factor
//  m_axis  | out       | tdata: res_real..res_k; tuser: unit, zero, sat flags
//  cfg     | in        | unit_tolerance (17 bits)
//
// One item per cycle sustained while m_axis accepts results. Each accepted item
// passes through 3 front stages (capture, squares, sum), 34 square-root stages,
// 66 division stages, 3 back stages (sign/clamp, products, sums) and the output buffer.
// Reset (aresetn low, synchronous) clears all valid bits and sets tolerance to 1.
// While a result waits in the output buffer and m_axis_tready is low, every stage
// holds; s_axis_tready follows m_axis_tready or an empty output buffer.
`default_nettype none
module quaternion_arith_unit_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [2:0] cmd, [34:3] a_real, [66:35] a_i, [98:67] a_j, [130:99] a_k,
    // [162:131] b_real, [194:163] b_i, [226:195] b_j, [258:227] b_k,
    // [290:259] scale_factor, [295:291] zero
    input  wire logic [295:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [31:0] res_real, [63:32] res_i, [95:64] res_j, [127:96] res_k
    output logic [127:0]       m_axis_tdata,
    // [0] unit_flag, [1] zero_flag, [2] sat_flag
    output logic [2:0]         m_axis_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [qau_pkg::TOLW-1:0] cfg_data
);
    import qau_pkg::*;

    localparam int NSQ = 33;   // isqrt result bits
    localparam int NDV = 65;   // quotient steps

    // per-item carried payload
    typedef struct packed {
        logic [CMDW-1:0] cmd;
        comp_t [3:0] a;
        comp_t [3:0] b;
        comp_t sf;
    } item_t;

    logic [TOLW-1:0] tol_reg;
    logic adv_ok;
    logic [1:0] cnt_reg;
    res_t fifo_reg [2];
    logic rp_reg, wp_reg;

    // ---------------- stage 0: capture
    logic v0_reg;
    item_t it0_reg;
    // ---------------- stage 1: squares
    logic v1_reg;
    item_t it1_reg;
    logic [63:0] sq_reg [4];
    // ---------------- stage 2: sum
    logic v2_reg;
    item_t it2_reg;
    logic [SW-1:0] s2_reg;

    // isqrt pipeline: NSQ stages
    logic vs_reg [NSQ+1];
    item_t its_reg [NSQ+1];
    logic [SW-1:0] ss_reg [NSQ+1];
    logic [67:0] srem_reg [NSQ+1];
    logic [NSQ-1:0] sroot_reg [NSQ+1];

    // division pipeline: 4 lanes inverse (denominator S) + 4 lanes normalise
    logic vd_reg [NDV+1];
    item_t itd_reg [NDV+1];
    logic [SW-1:0] sd_reg [NDV+1];
    logic [NSQ-1:0] md_reg [NDV+1];
    logic [65:0] ri_reg [NDV+1][4];
    logic [65:0] rn_reg [NDV+1][4];
    logic [NDV-1:0] qi_reg [NDV+1][4];
    logic [NDV-1:0] qn_reg [NDV+1][4];

    // post stages
    logic vp_reg, vq_reg, vr_reg;
    item_t itp_reg, itq_reg;
    logic fz_p_reg, fu_p_reg, sat_p_reg;
    comp_t t_p_reg [4];
    comp_t t_q_reg [4];
    logic signed [64:0] pr_reg [4][4];
    logic fz_q_reg, fu_q_reg, sat_q_reg;
    res_t res_reg;

    // pipeline moves when the output buffer is empty or drains this cycle
    assign adv_ok = m_axis_tready || (cnt_reg == 2'd0);
    assign s_axis_tready = adv_ok;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOLW'(1);
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // stage 0/1/2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv_ok) begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_ok) begin
            it0_reg.cmd <= s_axis_tdata[2:0];
            for (int c = 0; c < 4; c++) begin
                it0_reg.a[c] <= s_axis_tdata[3+32*c +: 32];
                it0_reg.b[c] <= s_axis_tdata[131+32*c +: 32];
            end
            it0_reg.sf <= s_axis_tdata[290:259];
            it1_reg <= it0_reg;
            for (int c = 0; c < 4; c++) begin
                sq_reg[c] <= 64'($signed(it0_reg.a[c]) * $signed(it0_reg.a[c]));
            end
            it2_reg <= it1_reg;
            s2_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
        end
    end

    // isqrt: bit-serial one result bit per stage, sqrt clamps at 2^32 when S>=2^64
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NSQ; k++) vs_reg[k] <= 1'b0;
        end else if (adv_ok) begin
            vs_reg[0] <= v2_reg;
            for (int k = 1; k <= NSQ; k++) vs_reg[k] <= vs_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [67:0] tr;
        logic [67:0] rem;
        logic [2*NSQ-1:0] rad;
        if (adv_ok) begin
            its_reg[0] <= it2_reg;
            ss_reg[0] <= s2_reg;
            srem_reg[0] <= '0;
            sroot_reg[0] <= '0;
            for (int k = 1; k <= NSQ; k++) begin
                its_reg[k] <= its_reg[k-1];
                ss_reg[k] <= ss_reg[k-1];
                // radicand padded to an even bit count, two bits per stage
                rad = {1'b0, ss_reg[k-1]};
                rem = {srem_reg[k-1][65:0], rad[2*(NSQ-k)+1 -: 2]};
                tr = {33'd0, sroot_reg[k-1], 2'b01};
                if (rem >= tr) begin
                    srem_reg[k] <= rem - tr;
                    sroot_reg[k] <= {sroot_reg[k-1][NSQ-2:0], 1'b1};
                end else begin
                    srem_reg[k] <= rem;
                    sroot_reg[k] <= {sroot_reg[k-1][NSQ-2:0], 1'b0};
                end
            end
        end
    end

    // division lanes
    logic [65:0] ri_n [NDV][4];
    logic [65:0] rn_n [NDV][4];
    logic qi_b [NDV][4];
    logic qn_b [NDV][4];
    logic [NSQ-1:0] mag_d;

    assign mag_d = ss_reg[NSQ][64] ? NSQ'(64'd4294967296) : sroot_reg[NSQ];

    // numerators: inverse m<<32 (64 bits), normalise m<<16 (48 bits); feed MSB first
    // over NDV=65 steps with the numerator stored in the quotient register slot.
    for (genvar k = 0; k < NDV; k++) begin : g_div
        for (genvar c = 0; c < 4; c++) begin : g_lane
            qau_div_stage u_inv (
                .rem_in (ri_reg[k][c]),
                .num_bit(qi_reg[k][c][NDV-1]),
                .den    ({1'b0, sd_reg[k]}),
                .rem_out(ri_n[k][c]),
                .q_bit  (qi_b[k][c])
            );
            qau_div_stage u_nrm (
                .rem_in (rn_reg[k][c]),
                .num_bit(qn_reg[k][c][NDV-1]),
                .den    (66'(md_reg[k])),
                .rem_out(rn_n[k][c]),
                .q_bit  (qn_b[k][c])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NDV; k++) vd_reg[k] <= 1'b0;
        end else if (adv_ok) begin
            vd_reg[0] <= vs_reg[NSQ];
            for (int k = 1; k <= NDV; k++) vd_reg[k] <= vd_reg[k-1];
        end
    end

    item_t itd_in;
    assign itd_in = its_reg[NSQ];

    always_ff @(posedge aclk) begin
        logic [63:0] m;
        if (adv_ok) begin
            itd_reg[0] <= itd_in;
            sd_reg[0] <= ss_reg[NSQ];
            md_reg[0] <= mag_d;
            for (int c = 0; c < 4; c++) begin
                m = itd_in.a[c][DW-1] ?
                    64'(-$signed({itd_in.a[c][DW-1], itd_in.a[c]})) : 64'(itd_in.a[c]);
                ri_reg[0][c] <= '0;
                rn_reg[0][c] <= '0;
                qi_reg[0][c] <= {1'b0, m} << 32;
                qn_reg[0][c] <= NDV'({1'b0, m} << 16);
            end
            for (int k = 1; k <= NDV; k++) begin
                itd_reg[k] <= itd_reg[k-1];
                sd_reg[k] <= sd_reg[k-1];
                md_reg[k] <= md_reg[k-1];
                for (int c = 0; c < 4; c++) begin
                    ri_reg[k][c] <= ri_n[k-1][c];
                    rn_reg[k][c] <= rn_n[k-1][c];
                    qi_reg[k][c] <= {qi_reg[k-1][c][NDV-2:0], qi_b[k-1][c]};
                    qn_reg[k][c] <= {qn_reg[k-1][c][NDV-2:0], qn_b[k-1][c]};
                end
            end
        end
    end

    // post stage P: flags, quotient signing/clamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
            vr_reg <= 1'b0;
        end else if (adv_ok) begin
            vp_reg <= vd_reg[NDV];
            vq_reg <= vp_reg;
            vr_reg <= vq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        item_t it;
        logic [NSQ-1:0] mg;
        logic [NSQ-1:0] dev;
        logic sat;
        logic neg;
        logic [NDV-1:0] q;
        if (adv_ok) begin
            it = itd_reg[NDV];
            mg = md_reg[NDV];
            dev = (mg > NSQ'(65536)) ? NSQ'(mg - NSQ'(65536)) : NSQ'(NSQ'(65536) - mg);
            fz_p_reg <= (sd_reg[NDV] == '0);
            fu_p_reg <= (dev < NSQ'(tol_reg));
            itp_reg <= it;
            sat = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (it.cmd == CMD_NORM) begin
                    neg = it.a[c][DW-1];
                    q = qn_reg[NDV][c];
                end else begin
                    neg = it.a[c][DW-1] ^ (c != 0);
                    q = qi_reg[NDV][c];
                end
                if (!neg && q > NDV'(64'h7FFFFFFF)) begin
                    t_p_reg[c] <= comp_t'(32'h7FFFFFFF);
                    sat = 1'b1;
                end else if (neg && q > NDV'(64'h80000000)) begin
                    t_p_reg[c] <= comp_t'(32'h80000000);
                    sat = 1'b1;
                end else begin
                    t_p_reg[c] <= neg ? comp_t'(-q[DW-1:0]) : comp_t'(q[DW-1:0]);
                end
            end
            // scale products are formed at stage Q and conj at stage R; only quotient sat kept here
            sat_p_reg <= sat && (sd_reg[NDV] != '0);
        end
    end

    // stage Q: products (Hamilton operand picks a or inverse)
    localparam int HA [4][4] = '{'{0,1,2,3}, '{0,1,2,3}, '{0,1,2,3}, '{0,1,2,3}};
    localparam int HB [4][4] = '{'{0,1,2,3}, '{1,0,3,2}, '{2,3,0,1}, '{3,2,1,0}};
    localparam int HS [4][4] = '{'{1,-1,-1,-1}, '{1,1,1,-1}, '{1,-1,1,1}, '{1,1,-1,1}};

    always_ff @(posedge aclk) begin
        comp_t x [4];
        logic signed [63:0] p;
        logic signed [64:0] pv;
        if (adv_ok) begin
            itq_reg <= itp_reg;
            fz_q_reg <= fz_p_reg;
            fu_q_reg <= fu_p_reg;
            sat_q_reg <= sat_p_reg && (itp_reg.cmd == CMD_INV || itp_reg.cmd == CMD_DIFF ||
                                       itp_reg.cmd == CMD_NORM);
            for (int c = 0; c < 4; c++) begin
                x[c] = (itp_reg.cmd == CMD_DIFF) ? t_p_reg[c] : itp_reg.a[c];
            end
            for (int c = 0; c < 4; c++) begin
                for (int t = 0; t < 4; t++) begin
                    p = '0;
                    if (itp_reg.cmd == CMD_SCALE) begin
                        if (t == 0) p = 64'($signed(itp_reg.a[c]) * $signed(itp_reg.sf));
                    end else begin
                        p = 64'($signed(x[HA[c][t]]) * $signed(itp_reg.b[HB[c][t]]));
                    end
                    pv = $signed({p[63], p});
                    if (HS[c][t] < 0 && itp_reg.cmd != CMD_SCALE) pv = -pv;
                    if (itp_reg.cmd != CMD_MULT && itp_reg.cmd != CMD_DIFF &&
                        itp_reg.cmd != CMD_SCALE) begin
                        pv = '0;
                    end
                    pr_reg[c][t] <= pv;
                end
            end
            for (int c = 0; c < 4; c++) t_q_reg[c] <= t_p_reg[c];
        end
    end

    // stage R: sums, shift, clamp, select
    always_ff @(posedge aclk) begin
        logic signed [80:0] hi;
        logic [80:0] lo;
        logic [DW:0] cl;
        logic sat;
        comp_t r [4];
        if (adv_ok) begin
            sat = sat_q_reg;
            for (int c = 0; c < 4; c++) begin
                hi = '0;
                lo = '0;
                for (int t = 0; t < 4; t++) begin
                    hi = hi + 81'(pr_reg[c][t] >>> FB);
                    lo = lo + 81'(pr_reg[c][t][FB-1:0]);
                end
                hi = hi + 81'(lo >> FB);
                cl = sat_clamp(hi);
                r[c] = '0;
                unique case (cmd_t'(itq_reg.cmd))
                    CMD_MULT, CMD_SCALE: begin
                        r[c] = cl[DW-1:0];
                        sat = sat | cl[DW];
                    end
                    CMD_DIFF: begin
                        if (!fz_q_reg) begin
                            r[c] = cl[DW-1:0];
                            sat = sat | cl[DW];
                        end
                    end
                    CMD_CONJ: begin
                        if (c == 0) begin
                            r[c] = itq_reg.a[0];
                        end else if (itq_reg.a[c] == comp_t'(32'h80000000)) begin
                            r[c] = comp_t'(32'h7FFFFFFF);
                            sat = 1'b1;
                        end else begin
                            r[c] = -itq_reg.a[c];
                        end
                    end
                    CMD_INV, CMD_NORM: begin
                        if (!fz_q_reg) r[c] = t_q_reg[c];
                    end
                    CMD_UNIT, CMD_SPARE: r[c] = '0;
                endcase
            end
            res_reg.r0 <= r[0];
            res_reg.r1 <= r[1];
            res_reg.r2 <= r[2];
            res_reg.r3 <= r[3];
            res_reg.unit_flag <= fu_q_reg;
            res_reg.zero_flag <= fz_q_reg;
            res_reg.sat_flag <= sat;
        end
    end

    // output buffer: pipeline advances only when the head can drain, so one slot suffices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rp_reg <= 1'b0;
            wp_reg <= 1'b0;
        end else begin
            if (adv_ok && vr_reg) begin
                fifo_reg[wp_reg] <= res_reg;
                wp_reg <= ~wp_reg;
            end
            if (m_axis_tvalid && m_axis_tready) rp_reg <= ~rp_reg;
            cnt_reg <= 2'(cnt_reg + 2'(adv_ok && vr_reg) - 2'(m_axis_tvalid && m_axis_tready));
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata = {fifo_reg[rp_reg].r3, fifo_reg[rp_reg].r2,
                           fifo_reg[rp_reg].r1, fifo_reg[rp_reg].r0};
    assign m_axis_tuser = {fifo_reg[rp_reg].sat_flag, fifo_reg[rp_reg].zero_flag,
                           fifo_reg[rp_reg].unit_flag};
endmodule
`default_nettype wire

### rtl/qau_div_stage.sv
// One restoring-division step used by the pipelined dividers.
// Depends on nothing beyond plain logic.
`default_nettype none
module qau_div_stage (
    input  wire logic [65:0] rem_in,
    input  wire logic        num_bit,
    input  wire logic [65:0] den,
    output logic      [65:0] rem_out,
    output logic             q_bit
);
    logic [66:0] trial;

    // shift in one numerator bit and try to subtract
    always_comb begin
        trial = {rem_in, num_bit};
        if (trial >= {1'b0, den}) begin
            rem_out = 66'(trial - {1'b0, den});
            q_bit = 1'b1;
        end else begin
            rem_out = trial[65:0];
            q_bit = 1'b0;
        end
    end
endmodule
`default_nettype wire
